// File: sv/fbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared widths and the record carried through the square root pipeline.
// ----------------------------------------------------------------------------
package fbm_pkg;

  localparam int unsigned IN_W    = 16;  // signed bin halves
  localparam int unsigned ABS_W   = 16;  // magnitude of one half, up to 32768
  localparam int unsigned SQ_W    = 31;  // one square, up to 2^30
  localparam int unsigned SUM_W   = 32;  // sum of squares, up to 2^31
  localparam int unsigned X_W     = 34;  // four times the sum
  localparam int unsigned ROOT_W  = 17;  // one root bit per step
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned MAG_MAX = 92681;

  typedef struct packed {
    logic [X_W-1:0]    x;     // radicand, consumed two bits per step from the top
    logic [REM_W-1:0]  rem;   // partial remainder
    logic [ROOT_W-1:0] root;  // partial root
    logic              dc;    // halve at the end
  } root_data_t;

endpackage

// File: sv/fft_bin_magnitude_core.sv
`timescale 1ns / 1ps
// pipeline: 3 sum-of-squares stages, 17 square root digit stages and
//   1 output stage between input transfer and result
// throughput: one bin per cycle; each pipeline stage holds one item and
//   empty stages fill while the output is stalled
// reset: synchronous active low, clears all stage valid bits only
// ----------------------------------------------------------------------------
// fft_bin_magnitude_core
// Doubled FFT bin magnitude floor(sqrt(4*(re^2+im^2))), halved for the DC bin.
// ----------------------------------------------------------------------------
module fft_bin_magnitude_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [fbm_pkg::IN_W-1:0] in_real_part,
  input  logic signed [fbm_pkg::IN_W-1:0] in_imag_part,
  input  logic                         in_dc_bin,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fbm_pkg::ROOT_W-1:0]   out_magnitude
);
  import fbm_pkg::*;

  logic       st_valid [0:ROOT_W];
  logic       st_ready [0:ROOT_W];
  root_data_t st_data  [0:ROOT_W];

  logic              sumsq_ready;
  logic              out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0] mag_r, mag_nxt;

  fbm_sumsq u_sumsq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (sumsq_ready),
    .real_part (in_real_part),
    .imag_part (in_imag_part),
    .dc_bin    (in_dc_bin),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_data  (st_data[0])
  );

  assign in_stall = !sumsq_ready;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    fbm_root_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_data   (st_data[k]),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_data  (st_data[k+1])
    );
  end

  assign st_ready[ROOT_W] = !out_valid_r || !out_stall;
  assign out_valid_nxt    = st_valid[ROOT_W] || (out_valid_r && out_stall);
  assign mag_nxt          = st_data[ROOT_W].dc ? (st_data[ROOT_W].root >> 1)
                                               : st_data[ROOT_W].root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid[ROOT_W] && st_ready[ROOT_W]) begin
      mag_r <= mag_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = mag_r;

endmodule

// File: sv/fbm_sumsq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_sumsq
// Three stages: absolute values, squares, sum. Emits the radicand record.
// ----------------------------------------------------------------------------
module fbm_sumsq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fbm_pkg::IN_W-1:0]   real_part,
  input  logic [fbm_pkg::IN_W-1:0]   imag_part,
  input  logic                       dc_bin,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fbm_pkg::root_data_t        out_data
);
  import fbm_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic rdy1, rdy2, rdy3;

  logic [ABS_W-1:0] are_r, aim_r, are_nxt, aim_nxt;
  logic             dc1_r, dc2_r, dc3_r;
  logic [2*ABS_W-1:0] prod_re, prod_im;
  logic [SQ_W-1:0]  sq_re_r, sq_im_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign v1_nxt = (in_valid && rdy1) || (v1_r && !rdy2);
  assign v2_nxt = (v1_r && rdy2) || (v2_r && !rdy3);
  assign v3_nxt = (v2_r && rdy3) || (v3_r && !out_ready);

  // two's complement negate; -32768 lands on 32768 unsigned
  assign are_nxt = real_part[IN_W-1] ? (~real_part + 16'd1) : real_part;
  assign aim_nxt = imag_part[IN_W-1] ? (~imag_part + 16'd1) : imag_part;

  assign prod_re = are_r * are_r;
  assign prod_im = aim_r * aim_r;

  assign sum_nxt = {1'b0, sq_re_r} + {1'b0, sq_im_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      are_r <= are_nxt;
      aim_r <= aim_nxt;
      dc1_r <= dc_bin;
    end
    if (v1_r && rdy2) begin
      sq_re_r <= prod_re[SQ_W-1:0];
      sq_im_r <= prod_im[SQ_W-1:0];
      dc2_r   <= dc1_r;
    end
    if (v2_r && rdy3) begin
      sum_r <= sum_nxt;
      dc3_r <= dc2_r;
    end
  end

  assign out_valid     = v3_r;
  assign out_data.x    = {sum_r, 2'b00};
  assign out_data.rem  = '0;
  assign out_data.root = '0;
  assign out_data.dc   = dc3_r;

endmodule

// File: sv/fbm_root_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_root_step
// One registered digit step of the restoring square root: one root bit.
// ----------------------------------------------------------------------------
module fbm_root_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fbm_pkg::root_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fbm_pkg::root_data_t out_data
);
  import fbm_pkg::*;

  logic       valid_r, valid_nxt;
  root_data_t data_r, data_nxt;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             take;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !out_ready);

  // bring down the next two radicand bits, try root*4+1
  assign rem_sh = {in_data.rem, in_data.x[X_W-1 -: 2]};
  assign trial  = {2'b00, in_data.root, 2'b01};
  assign diff   = rem_sh - trial;
  assign take   = (rem_sh >= trial);

  always_comb begin
    data_nxt.x    = {in_data.x[X_W-3:0], 2'b00};
    data_nxt.dc   = in_data.dc;
    data_nxt.rem  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    data_nxt.root = {in_data.root[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: sv/fbm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_checker
// Port-level checks on the magnitude core, bound to the top level.
// ----------------------------------------------------------------------------
module fbm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [fbm_pkg::ROOT_W-1:0] out_magnitude
);
  import fbm_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_magnitude))
    else $error("result changed while stalled");

  // empty output register means every stage can move, so input never stalls
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnitude <= ROOT_W'(MAG_MAX)))
    else $error("magnitude out of range");

  // no result is offered right after reset, before anything went in
  a_first_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind fft_bin_magnitude_core fbm_checker u_fbm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_magnitude (out_magnitude)
);
